/* src/rgbw_led_strip_pulse_encoder_core_assert.svh */
// Assertion macros for the LED strip pulse encoder.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RGBW_LED_STRIP_PULSE_ENCODER_CORE_ASSERT_SVH
`define RGBW_LED_STRIP_PULSE_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTH

// Condition must hold at every clock edge out of reset.
`define RLPE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent in a cycle implies consequent in the same cycle.
`define RLPE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent in a cycle implies consequent in the next cycle.
`define RLPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RLPE_ASSERT_ALWAYS(lbl, cond)
`define RLPE_ASSERT_IMPLY(lbl, ante, cons)
`define RLPE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/rlpe_pkg.sv */
`default_nettype none

package rlpe_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_DATA_W = 16;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_ZERO_HIGH  = 2'd0;
    localparam cfg_index_t REG_ONE_HIGH   = 2'd1;
    localparam cfg_index_t REG_BIT_PERIOD = 2'd2;
    localparam cfg_index_t REG_RESET_GAP  = 2'd3;

    typedef struct packed {
        logic              is_load;
        logic [WORD_W-1:0] word;
        logic              last;
    } rlpe_item_t;

    typedef struct packed {
        logic data_line;
        logic load_accepted;
        logic busy;
        logic frame_done;
        logic underrun;
    } rlpe_result_t;

endpackage

`default_nettype wire

/* src/rlpe_front.sv */
`default_nettype none

module rlpe_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                kind,
    input  wire logic [31:0]         pixel_word,
    input  wire logic                last_pixel,
    input  wire logic                take,
    output logic                     avail,
    output rlpe_pkg::rlpe_item_t     item
);
    import rlpe_pkg::*;

    rlpe_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    rlpe_item_t incoming;

    assign full   = (count_reg == 2'd2);
    assign avail  = (count_reg != 2'd0);
    assign accept = push && !full;
    assign item   = entry_reg[rd_ptr_reg];

    // classify: kind high marks a pixel load, low a time tick
    always_comb
    begin
        incoming.is_load = kind;
        incoming.word    = pixel_word;
        incoming.last    = last_pixel;
    end

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({accept, take})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

/* src/rlpe_engine.sv */
`default_nettype none

module rlpe_engine #(
    parameter int BITS_PER_PIXEL = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire rlpe_pkg::rlpe_item_t item,
    output rlpe_pkg::rlpe_result_t   result,
    input  wire logic                cfg_write,
    input  wire rlpe_pkg::cfg_index_t cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import rlpe_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    localparam int BITS_MOD = BITS_PER_PIXEL % 64;
    localparam logic [5:0] BITS_INIT = 6'((BITS_MOD == 0) ? 1 : BITS_MOD);

    logic [7:0]        zero_high_reg;
    logic [7:0]        one_high_reg;
    logic [7:0]        period_reg;
    logic [15:0]       gap_reg;

    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [WORD_W-1:0] hold_word_reg, hold_word_next;
    logic              hold_valid_reg, hold_valid_next;
    logic              hold_last_reg, hold_last_next;
    logic              send_last_reg, send_last_next;
    logic [5:0]        bits_reg, bits_next;
    logic [15:0]       tick_reg, tick_next;
    logic [1:0]        phase_reg, phase_next;

    logic [7:0]        period_eff;
    logic [15:0]       gap_eff;

    assign period_eff = (period_reg == 8'd0) ? 8'd1 : period_reg;
    assign gap_eff    = (gap_reg == 16'd0) ? 16'd1 : gap_reg;

    always_comb
    begin : step
        logic [7:0]  high;
        logic [15:0] tick_inc;

        high     = 8'd0;
        tick_inc = 16'd0;

        shift_next      = shift_reg;
        hold_word_next  = hold_word_reg;
        hold_valid_next = hold_valid_reg;
        hold_last_next  = hold_last_reg;
        send_last_next  = send_last_reg;
        bits_next       = bits_reg;
        tick_next       = tick_reg;
        phase_next      = phase_reg;
        result          = '0;

        if (item.is_load)
        begin
            // drop a load that finds the holding register taken
            if (!hold_valid_reg)
            begin
                hold_word_next       = item.word;
                hold_last_next       = item.last;
                hold_valid_next      = 1'b1;
                result.load_accepted = 1'b1;
            end
        end
        else
        begin
            if (phase_reg == PH_IDLE && hold_valid_reg)
            begin
                shift_next      = hold_word_reg;
                send_last_next  = hold_last_reg;
                hold_valid_next = 1'b0;
                bits_next       = BITS_INIT;
                tick_next       = 16'd0;
                phase_next      = PH_SEND;
            end

            unique case (phase_next)
                PH_SEND:
                begin
                    high = shift_next[WORD_W-1] ? one_high_reg : zero_high_reg;
                    result.data_line = (tick_next < {8'd0, high});
                    tick_inc = tick_next + 16'd1;
                    if (tick_inc >= {8'd0, period_eff})
                    begin
                        tick_next  = 16'd0;
                        shift_next = {shift_next[WORD_W-2:0], 1'b0};
                        bits_next  = bits_next - 6'd1;
                        if (bits_next == 6'd0)
                        begin
                            // chain the held pixel with no gap, else close the frame
                            if (!send_last_next && hold_valid_next)
                            begin
                                shift_next      = hold_word_reg;
                                send_last_next  = hold_last_reg;
                                hold_valid_next = 1'b0;
                                bits_next       = BITS_INIT;
                                tick_next       = 16'd0;
                                phase_next      = PH_SEND;
                            end
                            else
                            begin
                                result.underrun = !send_last_next;
                                phase_next      = PH_GAP;
                            end
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                PH_GAP:
                begin
                    tick_inc = tick_next + 16'd1;
                    if (tick_inc >= gap_eff)
                    begin
                        tick_next         = 16'd0;
                        phase_next        = PH_IDLE;
                        result.frame_done = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        result.busy = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= '0;
            hold_valid_reg <= 1'b0;
            hold_last_reg  <= 1'b0;
            send_last_reg  <= 1'b0;
            bits_reg       <= 6'd0;
            tick_reg       <= 16'd0;
            phase_reg      <= PH_IDLE;
        end
        else if (go)
        begin
            shift_reg      <= shift_next;
            hold_valid_reg <= hold_valid_next;
            hold_last_reg  <= hold_last_next;
            send_last_reg  <= send_last_next;
            bits_reg       <= bits_next;
            tick_reg       <= tick_next;
            phase_reg      <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            hold_word_reg <= hold_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg <= 8'd6;
            one_high_reg  <= 8'd14;
            period_reg    <= 8'd21;
            gap_reg       <= 16'd1280;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ZERO_HIGH:  zero_high_reg <= cfg_data[7:0];
                REG_ONE_HIGH:   one_high_reg  <= cfg_data[7:0];
                REG_BIT_PERIOD: period_reg    <= cfg_data[7:0];
                REG_RESET_GAP:  gap_reg       <= cfg_data;
                default:        gap_reg       <= gap_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/rlpe_result_queue.sv */
`default_nettype none

module rlpe_result_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                put,
    input  wire rlpe_pkg::rlpe_result_t put_data,
    output logic                     room,
    output logic                     empty,
    input  wire logic                pop,
    output rlpe_pkg::rlpe_result_t   head
);
    import rlpe_pkg::*;

    rlpe_result_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         take;

    assign room  = (count_reg != 2'd2);
    assign empty = (count_reg == 2'd0);
    assign take  = pop && !empty;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = put ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({put, take})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            entry_reg[wr_ptr_reg] <= put_data;
        end
    end

endmodule

`default_nettype wire

/* src/rgbw_led_strip_pulse_encoder_core.sv */
// Channel    Handshake          Payload
// input      push / full        kind, pixel_word, last_pixel
// result     empty / pop        data_line, load_accepted, busy_res, frame_done, underrun
// config     cfg_write          cfg_index, cfg_data
//
// One item per cycle sustained while the result queue has room; each item yields one result.
// From push to result an item is registered in the two-entry input queue,
// then passes through the encoder step into the two-entry result queue.
// The encoder step runs whenever an item is queued and the result queue has room,
// so a stalled pop holds the encoder and fills the input queue before full rises.
// Reset clears both queues, the encoder state and loads the default timing.
`default_nettype none
`include "rgbw_led_strip_pulse_encoder_core_assert.svh"

module rgbw_led_strip_pulse_encoder_core #(
    parameter int BITS_PER_PIXEL = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 kind,
    input  wire logic [31:0]          pixel_word,
    input  wire logic                 last_pixel,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      data_line,
    output logic                      load_accepted,
    output logic                      busy_res,
    output logic                      frame_done,
    output logic                      underrun,
    input  wire logic                 cfg_write,
    input  wire rlpe_pkg::cfg_index_t cfg_index,
    input  wire logic [15:0]          cfg_data
);
    import rlpe_pkg::*;

    rlpe_item_t   item;
    rlpe_result_t result;
    rlpe_result_t head;
    logic         avail;
    logic         room;
    logic         go;

    assign go = avail && room;

    rlpe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .pixel_word (pixel_word),
        .last_pixel (last_pixel),
        .take       (go),
        .avail      (avail),
        .item       (item)
    );

    rlpe_engine #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .item      (item),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rlpe_result_queue u_results (
        .clk      (clk),
        .rst_n    (rst_n),
        .put      (go),
        .put_data (result),
        .room     (room),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign data_line     = head.data_line;
    assign load_accepted = head.load_accepted;
    assign busy_res      = head.busy;
    assign frame_done    = head.frame_done;
    assign underrun      = head.underrun;

    // a high line level only comes from a bit in flight, so the block stays busy
    `RLPE_ASSERT_IMPLY(a_line_busy, !empty && data_line, busy_res && !frame_done)
    // the end of a frame leaves the block idle with the line low
    `RLPE_ASSERT_IMPLY(a_done_idle, !empty && frame_done, !busy_res && !data_line && !underrun)
    // an underrun always starts the reset gap
    `RLPE_ASSERT_IMPLY(a_under_gap, !empty && underrun, busy_res && !load_accepted)
    // no result appears without an encoder step
    `RLPE_ASSERT_NEXT(a_no_phantom, empty && !go, empty)

endmodule

`default_nettype wire

/* test/rgbw_led_strip_pulse_encoder_core_test.sv */
module rgbw_led_strip_pulse_encoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rlpe_pkg::*;

    localparam int PIXEL_BITS   = 32;
    localparam int TARGET_ITEMS = 800;
    localparam int QUIET_LIMIT  = 400;
    localparam int HOLD_CYCLES  = 60;

    typedef enum logic [1:0] {EP_IDLE, EP_SEND, EP_GAP} enc_phase_t;
    typedef enum logic [1:0] {SO_ITEM, SO_TIMING, SO_DRAIN} stim_op_t;

    typedef struct {
        stim_op_t   op;
        rlpe_item_t item;
        cfg_index_t idx;
        logic [15:0] data;
    } stim_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        kind       = 1'b0;
    logic [31:0] pixel_word = '0;
    logic        last_pixel = 1'b0;
    logic        pop        = 1'b0;
    logic        cfg_write  = 1'b0;
    cfg_index_t  cfg_index  = REG_ZERO_HIGH;
    logic [15:0] cfg_data   = '0;
    logic        full, empty;
    logic        data_line, load_accepted, busy_res, frame_done, underrun;

    rgbw_led_strip_pulse_encoder_core #(
        .BITS_PER_PIXEL(PIXEL_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .pixel_word   (pixel_word),
        .last_pixel   (last_pixel),
        .empty        (empty),
        .pop          (pop),
        .data_line    (data_line),
        .load_accepted(load_accepted),
        .busy_res     (busy_res),
        .frame_done   (frame_done),
        .underrun     (underrun),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Encoder timing as the block sees it
    logic [7:0]  zero_hi  = 8'd6;
    logic [7:0]  one_hi   = 8'd14;
    logic [7:0]  bit_per  = 8'd21;
    logic [15:0] gap_len  = 16'd1280;

    // Encoder state
    logic [31:0] shift_px   = '0;
    logic [31:0] held_px    = '0;
    logic        held_valid = 1'b0;
    logic        held_last  = 1'b0;
    logic        shift_last = 1'b0;
    logic [5:0]  bits_left  = '0;
    logic [15:0] tick_cnt   = '0;
    enc_phase_t  enc_phase  = EP_IDLE;

    stim_t        stim_q[$];
    rlpe_result_t line_results_due[$];

    // Generator view of the timing, used only to size frames
    int gen_period = 21;
    int gen_gap    = 1280;
    int n_gen      = 0;

    logic item_taken   = 1'b0;
    logic result_taken = 1'b0;
    int   send_wait    = 0;
    int   pop_wait     = 0;
    int   hold_left    = 0;
    int   hold_at      = 150;
    int   quiet_cycles = 0;

    int items_sent     = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int loads_taken    = 0;
    int loads_dropped  = 0;
    int frames_seen    = 0;
    int underruns_seen = 0;
    int timing_writes  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_draw(int n);
        // every third stretch of 50 items runs back to back
        return ((n / 50) % 3 == 2) ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic void take_held_pixel();
        shift_px   = held_px;
        shift_last = held_last;
        held_valid = 1'b0;
        bits_left  = 6'(PIXEL_BITS);
        if (bits_left == 0)
            bits_left = 6'd1;
        tick_cnt  = '0;
        enc_phase = EP_SEND;
    endfunction

    function automatic rlpe_result_t encode_step(rlpe_item_t it);
        rlpe_result_t r;
        logic [7:0]   high;
        logic [7:0]   per;
        logic [15:0]  gap_t;
        r = '0;
        if (it.is_load)
        begin
            if (!held_valid)
            begin
                held_px         = it.word;
                held_last       = it.last;
                held_valid      = 1'b1;
                r.load_accepted = 1'b1;
            end
        end
        else
        begin
            if (enc_phase == EP_IDLE && held_valid)
                take_held_pixel();
            if (enc_phase == EP_SEND)
            begin
                high        = shift_px[31] ? one_hi : zero_hi;
                per         = (bit_per == 0) ? 8'd1 : bit_per;
                r.data_line = (tick_cnt < high);
                tick_cnt    = tick_cnt + 16'd1;
                if (tick_cnt >= per)
                begin
                    tick_cnt  = '0;
                    shift_px  = shift_px << 1;
                    bits_left = bits_left - 6'd1;
                    if (bits_left == 0)
                    begin
                        if (!shift_last && held_valid)
                            take_held_pixel();
                        else
                        begin
                            r.underrun = !shift_last;
                            enc_phase  = EP_GAP;
                        end
                    end
                end
            end
            else if (enc_phase == EP_GAP)
            begin
                gap_t    = (gap_len == 0) ? 16'd1 : gap_len;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= gap_t)
                begin
                    tick_cnt     = '0;
                    enc_phase    = EP_IDLE;
                    r.frame_done = 1'b1;
                end
            end
        end
        r.busy = (enc_phase != EP_IDLE);
        return r;
    endfunction

    task automatic queue_item(logic is_load, logic [31:0] word, logic last);
        stim_t s;
        s.op   = SO_ITEM;
        s.item = '{is_load: is_load, word: word, last: last};
        s.idx  = REG_ZERO_HIGH;
        s.data = '0;
        stim_q.push_back(s);
        n_gen++;
    endtask

    task automatic queue_ticks(int n);
        for (int t = 0; t < n; t++)
            queue_item(1'b0, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_timing(int zh, int oh, int per, int gap);
        stim_t s;
        s.item = '0;
        s.op   = SO_DRAIN;
        s.idx  = REG_ZERO_HIGH;
        s.data = '0;
        stim_q.push_back(s);
        s.op   = SO_TIMING;
        // upper bits of the 8-bit registers carry junk that must be ignored
        s.idx  = REG_ZERO_HIGH;
        s.data = {8'($urandom), 8'(zh)};
        stim_q.push_back(s);
        s.idx  = REG_ONE_HIGH;
        s.data = {8'($urandom), 8'(oh)};
        stim_q.push_back(s);
        s.idx  = REG_BIT_PERIOD;
        s.data = {8'($urandom), 8'(per)};
        stim_q.push_back(s);
        s.idx  = REG_RESET_GAP;
        s.data = 16'(gap);
        stim_q.push_back(s);
        gen_period = (per == 0) ? 1 : per;
        gen_gap    = (gap == 0) ? 1 : gap;
    endtask

    // One frame of npix pixels; now and then the next pixel is withheld.
    task automatic queue_frame(int npix);
        int tpix;
        int cut;
        int tail;
        int early;
        bit broken;
        tpix = PIXEL_BITS * gen_period;
        queue_item(1'b1, $urandom, npix == 1);
        for (int i = 0; i < npix; i++)
        begin
            broken = (i < npix - 1) && ($urandom_range(0, 4) == 0);
            cut    = $urandom_range(1, tpix - 1);
            for (int t = 0; t < tpix; t++)
            begin
                if (t == cut && i < npix - 1 && !broken)
                    queue_item(1'b1, $urandom, i + 2 == npix);
                else if ($urandom_range(0, 39) == 0)
                    queue_item(1'b1, $urandom, 1'($urandom_range(0, 1)));
                queue_item(1'b0, $urandom, 1'($urandom_range(0, 1)));
            end
            if (broken)
                break;
        end
        tail  = gen_gap + $urandom_range(0, 4);
        early = ($urandom_range(0, 2) == 0) ? $urandom_range(0, tail - 1) : -1;
        for (int t = 0; t < tail; t++)
        begin
            // a pixel arriving during the gap waits for the next frame
            if (t == early)
                queue_item(1'b1, $urandom, 1'($urandom_range(0, 1)));
            queue_item(1'b0, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic queue_phase(int zh, int oh, int per, int gap, int budget);
        int start;
        queue_timing(zh, oh, per, gap);
        start = n_gen;
        do
            queue_frame($urandom_range(1, 3));
        while (n_gen - start < budget);
    endtask

    // Input side: one item at a time from stim_q
    always @(negedge clk)
    begin : send_items
        logic next_push;
        logic next_wr;
        next_push = push;
        next_wr   = 1'b0;
        if (rst_n)
        begin
            if (push && item_taken)
            begin
                next_push = 1'b0;
                send_wait = idle_draw(items_sent);
                items_sent++;
            end
            if (!next_push)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (stim_q.size() > 0)
                begin
                    case (stim_q[0].op)
                        SO_ITEM:
                        begin
                            kind       <= stim_q[0].item.is_load;
                            pixel_word <= stim_q[0].item.word;
                            last_pixel <= stim_q[0].item.last;
                            next_push  = 1'b1;
                            void'(stim_q.pop_front());
                        end
                        SO_TIMING:
                        begin
                            next_wr   = 1'b1;
                            cfg_index <= stim_q[0].idx;
                            cfg_data  <= stim_q[0].data;
                            case (stim_q[0].idx)
                                REG_ZERO_HIGH:  zero_hi = stim_q[0].data[7:0];
                                REG_ONE_HIGH:   one_hi  = stim_q[0].data[7:0];
                                REG_BIT_PERIOD: bit_per = stim_q[0].data[7:0];
                                REG_RESET_GAP:  gap_len = stim_q[0].data;
                                default: ;
                            endcase
                            timing_writes++;
                            void'(stim_q.pop_front());
                        end
                        SO_DRAIN:
                        begin
                            // hold until every result is back
                            if (line_results_due.size() == 0)
                                void'(stim_q.pop_front());
                        end
                        default: ;
                    endcase
                end
            end
        end
        push      <= next_push;
        cfg_write <= next_wr;
    end

    // Result side: random pops plus long hold-offs that back up the block
    always @(negedge clk)
    begin : take_results
        logic next_pop;
        next_pop = pop;
        if (rst_n)
        begin
            if (pop && result_taken)
            begin
                next_pop = 1'b0;
                pop_wait = idle_draw(results_seen);
            end
            if (results_seen >= hold_at)
            begin
                hold_left = HOLD_CYCLES;
                hold_at   += 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_pop = 1'b0;
            end
            else if (!next_pop)
            begin
                if (pop_wait > 0)
                    pop_wait--;
                else
                    next_pop = 1'b1;
            end
        end
        pop <= next_pop;
    end

    always @(posedge clk)
    begin : watch_ports
        rlpe_result_t exp_r;
        rlpe_result_t got_r;
        logic         in_fire;
        logic         out_fire;
        in_fire  = rst_n && push && !full;
        out_fire = rst_n && pop && !empty;
        item_taken   <= in_fire;
        result_taken <= out_fire;
        if (in_fire)
        begin
            exp_r = encode_step('{is_load: kind, word: pixel_word, last: last_pixel});
            line_results_due.push_back(exp_r);
            if (kind)
            begin
                if (exp_r.load_accepted)
                    loads_taken++;
                else
                    loads_dropped++;
            end
            if (exp_r.frame_done)
                frames_seen++;
            if (exp_r.underrun)
                underruns_seen++;
        end
        if (out_fire)
        begin
            got_r = '{data_line: data_line, load_accepted: load_accepted, busy: busy_res,
                      frame_done: frame_done, underrun: underrun};
            if (line_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing outstanding", results_seen);
            end
            else
            begin
                exp_r = line_results_due.pop_front();
                if (got_r !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: expected line=%b acc=%b busy=%b done=%b under=%b",
                                 results_seen, exp_r.data_line, exp_r.load_accepted,
                                 exp_r.busy, exp_r.frame_done, exp_r.underrun);
                        $display("result %0d: got      line=%b acc=%b busy=%b done=%b under=%b",
                                 results_seen, got_r.data_line, got_r.load_accepted,
                                 got_r.busy, got_r.frame_done, got_r.underrun);
                    end
                end
            end
            results_seen++;
        end
        if (in_fire || out_fire || cfg_write || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no progress for %0d cycles, %0d results outstanding",
                     quiet_cycles, line_results_due.size());
            $display("rgbw_led_strip_pulse_encoder_core regression: fail");
            $finish;
        end
    end

    initial
    begin : run_test
        int start;
        // reset timing: idle tick, loads against a full holding register, first bits
        queue_item(1'b0, 32'h0, 1'b0);
        queue_item(1'b1, 32'hFFFF_FFFF, 1'b1);
        queue_item(1'b1, 32'h0000_0000, 1'b0);
        queue_ticks(3);
        queue_item(1'b1, 32'h0000_0000, 1'b0);
        queue_item(1'b1, 32'hFFFF_FFFF, 1'b1);
        queue_ticks(19);

        queue_phase(1, 2, 3, 4, 60);
        queue_phase(0, 1, 1, 0, 60);
        queue_phase(3, 255, 4, 2, 60);
        queue_phase(2, 1, 0, 1, 60);

        // widest timing: run part of a pixel, then stop inside it
        queue_timing(255, 255, 255, 65535);
        queue_item(1'b1, $urandom, 1'b0);
        queue_ticks(150);
        queue_item(1'b1, $urandom, 1'b1);
        queue_ticks(40);

        while (n_gen < TARGET_ITEMS)
        begin
            queue_timing($urandom_range(0, 5), $urandom_range(0, 6),
                         $urandom_range(0, 3), $urandom_range(0, 12));
            start = n_gen;
            do
                queue_frame($urandom_range(1, 3));
            while (n_gen - start < 100);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (stim_q.size() != 0 || push || line_results_due.size() != 0);
        repeat (8) @(negedge clk);

        $display("sent %0d items: %0d pixel loads taken, %0d dropped, %0d timing writes",
                 items_sent, loads_taken, loads_dropped, timing_writes);
        $display("checked %0d results: %0d frames latched, %0d underruns, %0d mismatches",
                 results_seen, frames_seen, underruns_seen, mismatches);
        if (line_results_due.size() != 0)
            $display("%0d results never arrived", line_results_due.size());
        if (mismatches == 0 && line_results_due.size() == 0)
            $display("rgbw_led_strip_pulse_encoder_core regression: pass");
        else
            $display("rgbw_led_strip_pulse_encoder_core regression: fail");
        $finish;
    end

endmodule

/* rgbw_led_strip_pulse_encoder_core.f */
+incdir+src
src/rlpe_pkg.sv
src/rlpe_front.sv
src/rlpe_engine.sv
src/rlpe_result_queue.sv
src/rgbw_led_strip_pulse_encoder_core.sv
test/rgbw_led_strip_pulse_encoder_core_test.sv
